/* hw/rtl/vibrato_tone_synth_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vibrato tone synthesizer
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VIBRATO_TONE_SYNTH_ASSERT_SVH
`define VIBRATO_TONE_SYNTH_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define VTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define VTS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define VTS_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/vts_pkg.sv */
// ----------------------------------------------------------------------------
// vts_pkg
// Shared types, constants and table builders for the vibrato tone synthesizer.
// ----------------------------------------------------------------------------
package vts_pkg;

  // Default sizes handed to the top level parameters.
  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int TANH_ADDR_BITS_DEF = 10;

  // Fixed field and table widths.
  localparam int TABLE_W    = 16;
  localparam int FREQ_W     = 16;
  localparam int VOL_W      = 9;
  localparam int SAMPLE_W   = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 32;
  localparam int DEPTH_W    = 16;
  localparam int SCALE_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int LEVEL_W    = 8;

  // Register reset values.
  localparam logic [STEP_W-1:0]  LFO_FAST_STEP_RST   = 32'd1266108;
  localparam logic [STEP_W-1:0]  LFO_SLOW_STEP_RST   = 32'd97393;
  localparam logic [DEPTH_W-1:0] LFO_FAST_DEPTH_RST  = 16'd3932;
  localparam logic [DEPTH_W-1:0] LFO_SLOW_DEPTH_RST  = 16'd6554;
  localparam logic [SCALE_W-1:0] FREQ_SCALE_RST      = 24'd3116441;
  localparam logic [GAIN_W-1:0]  DRIVE_GAIN_RST      = 16'd10240;
  localparam logic [LEVEL_W-1:0] OUTPUT_SWING_RST    = 8'd120;
  localparam logic [LEVEL_W-1:0] OUTPUT_MIDPOINT_RST = 8'd128;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LFO_FAST_STEP,
    REG_LFO_SLOW_STEP,
    REG_LFO_FAST_DEPTH,
    REG_LFO_SLOW_DEPTH,
    REG_FREQ_SCALE,
    REG_DRIVE_GAIN,
    REG_OUTPUT_SWING,
    REG_OUTPUT_MIDPOINT
  } reg_idx_t;

  // Sequencer steps, one shared multiply per step at most.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FAST,
    ST_RD_SLOW,
    ST_VIB,
    ST_BASE,
    ST_PHI,
    ST_PLO,
    ST_LOW,
    ST_STEP,
    ST_ADV,
    ST_RD_TONE,
    ST_MAG,
    ST_DRV,
    ST_TADDR,
    ST_SWING,
    ST_OUT
  } state_t;

  // Fixed-point constants for the table builders.
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned ONE_Q24     = 64'd1 << 24;

  // Unsigned long division by shift and subtract, used while building tables.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of a Q30 angle in 0..pi/2 by Taylor series, rounded to Q1.15.
  function automatic logic [TABLE_W-1:0] quarter_sine(input longint unsigned x);
    longint           sum;
    longint unsigned  t;
    longint unsigned  div;
    sum = longint'(x);
    t   = x;
    for (int n = 1; n <= 7; n++) begin
      div = 64'((2 * n) * (2 * n + 1));
      t   = (t * x) >> 30;
      t   = udiv((t * x) >> 30, div);
      if ((n & 1) != 0) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      sum = 64'sd32767;
    end
    return TABLE_W'(sum);
  endfunction

  // Entry i of a full-cycle sine table with 2^abits entries.
  function automatic logic [TABLE_W-1:0] sine_entry(input int unsigned i,
                                                    input int unsigned abits);
    int unsigned       sh;
    int unsigned       quad;
    int unsigned       k;
    int unsigned       a;
    longint unsigned   x;
    logic [TABLE_W-1:0] v;
    sh   = abits - 2;
    quad = i >> sh;
    k    = i & ((32'd1 << sh) - 1);
    a    = ((quad & 1) != 0) ? ((32'd1 << sh) - k) : k;
    x    = (PI_HALF_Q30 * 64'(a)) >> sh;
    v    = quarter_sine(x);
    return ((quad & 2) != 0) ? TABLE_W'(-v) : v;
  endfunction

  // Entry j of the tanh table over 0..4, through exp of twice the argument.
  function automatic logic [TABLE_W-1:0] tanh_entry(input int unsigned j,
                                                    input int unsigned abits);
    longint unsigned z;
    longint unsigned sum;
    longint unsigned t;
    longint unsigned e;
    longint unsigned q;
    z   = 64'(j) << (29 - abits);
    sum = ONE_Q30;
    t   = ONE_Q30;
    for (int n = 1; n <= 12; n++) begin
      t   = udiv((t * z) >> 30, 64'(n));
      sum = sum + t;
    end
    e = sum >> 6;
    for (int n = 0; n < 4; n++) begin
      e = (e * e) >> 24;
    end
    q = udiv(((e - ONE_Q24) << 15) + ((e + ONE_Q24) >> 1), e + ONE_Q24);
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return TABLE_W'(q);
  endfunction

endpackage

/* hw/rtl/vts_tables.sv */
// ----------------------------------------------------------------------------
// vts_tables
// Constant sine and tanh lookup tables with registered reads.
// ----------------------------------------------------------------------------
module vts_tables import vts_pkg::*; #(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int TANH_ADDR_BITS = TANH_ADDR_BITS_DEF
) (
  input  logic                      clk,
  input  logic [SINE_ADDR_BITS-1:0] sine_addr,
  input  logic [TANH_ADDR_BITS-1:0] tanh_addr,
  output logic signed [TABLE_W-1:0] sine_q,
  output logic [TABLE_W-1:0]        tanh_q
);

  localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
  localparam int TANH_SIZE = 1 << TANH_ADDR_BITS;

  logic [TABLE_W-1:0] sine_rom [SINE_SIZE];
  logic [TABLE_W-1:0] tanh_rom [TANH_SIZE];

  // Table contents are fixed at elaboration.
  for (genvar gi = 0; gi < SINE_SIZE; gi++) begin : g_sine
    localparam logic [TABLE_W-1:0] ENTRY = sine_entry(gi, SINE_ADDR_BITS);
    assign sine_rom[gi] = ENTRY;
  end

  for (genvar gj = 0; gj < TANH_SIZE; gj++) begin : g_tanh
    localparam logic [TABLE_W-1:0] ENTRY = tanh_entry(gj, TANH_ADDR_BITS);
    assign tanh_rom[gj] = ENTRY;
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    sine_q <= $signed(sine_rom[sine_addr]);
    tanh_q <= tanh_rom[tanh_addr];
  end

endmodule

/* hw/rtl/vibrato_tone_synth.sv */
// ----------------------------------------------------------------------------
// vibrato_tone_synth
// Sine tone generator with two-LFO vibrato, tanh soft clip and 8-bit output.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the s_t* channel (tone frequency in Q12.4 Hz and a Q1.8
//   volume) produces exactly one 8-bit sample word on the m_t* channel.
//   The cfg_* channel writes the eight setup registers by index; it is always
//   ready and should only be written while no sample is being computed.
// Timing:
//   A small sequencer runs all arithmetic through one shared signed
//   multiplier and the registered table reads, one step per cycle.
//   m_tvalid and s_tready both rise together when the sequencer leaves its
//   last step, so a new word is taken only once the current one is done.
//   The finished sample sits in an output register, so the next word is
//   accepted while it waits. If the receiver still holds off when the next
//   sample is ready, the sequencer waits in its last step.
// Reset:
//   rst clears the three phase accumulators, loads the default register
//   values, drops m_tvalid and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module vibrato_tone_synth import vts_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int TANH_ADDR_BITS = TANH_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] tone_freq, [24:16] volume
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] sample
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 50;
  localparam int TSHIFT  = 37 - TANH_ADDR_BITS;
  localparam int XSH_W   = 40 - TSHIFT;

  // Setup registers.
  logic [STEP_W-1:0]  lfo_fast_step;
  logic [STEP_W-1:0]  lfo_slow_step;
  logic [DEPTH_W-1:0] lfo_fast_depth;
  logic [DEPTH_W-1:0] lfo_slow_depth;
  logic [SCALE_W-1:0] freq_scale;
  logic [GAIN_W-1:0]  drive_gain;
  logic [LEVEL_W-1:0] output_swing;
  logic [LEVEL_W-1:0] output_midpoint;

  // Phase accumulators.
  logic [PHASE_BITS-1:0] tone_phase;
  logic [PHASE_BITS-1:0] fast_lfo_phase;
  logic [PHASE_BITS-1:0] slow_lfo_phase;

  // Sequencer and datapath registers.
  state_t                 state;
  state_t                 state_next;
  logic                   out_load;
  logic [FREQ_W-1:0]      tone_freq;
  logic [VOL_W-1:0]       volume;
  logic [ACC_W-1:0]       acc;
  logic [49:0]            p_hi;
  logic [31:0]            base;
  logic [32:0]            mag;
  logic                   vib_neg;
  logic                   sine_neg;
  logic [PHASE_BITS-1:0]  step;
  logic [SAMPLE_W-1:0]    sample;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // Table interface.
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [TANH_ADDR_BITS-1:0] tanh_addr;
  logic signed [TABLE_W-1:0] sine_q;
  logic [TABLE_W-1:0]        tanh_q;

  // Derived values.
  logic [TABLE_W-1:0]        sine_abs;
  logic signed [TABLE_W:0]   tanh_signed;
  logic [ACC_W-1:0]          acc_abs;
  logic [34:0]               step_sum;
  logic [XSH_W-1:0]          x_sh;
  logic signed [25:0]        total;
  logic [SAMPLE_W-1:0]       sample_next;

  assign cfg_ready = 1'b1;
  assign m_tdata   = sample;

  // Configuration writes; all eight indexes map to a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_fast_step   <= LFO_FAST_STEP_RST;
      lfo_slow_step   <= LFO_SLOW_STEP_RST;
      lfo_fast_depth  <= LFO_FAST_DEPTH_RST;
      lfo_slow_depth  <= LFO_SLOW_DEPTH_RST;
      freq_scale      <= FREQ_SCALE_RST;
      drive_gain      <= DRIVE_GAIN_RST;
      output_swing    <= OUTPUT_SWING_RST;
      output_midpoint <= OUTPUT_MIDPOINT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_LFO_FAST_STEP:   lfo_fast_step   <= cfg_data[STEP_W-1:0];
        REG_LFO_SLOW_STEP:   lfo_slow_step   <= cfg_data[STEP_W-1:0];
        REG_LFO_FAST_DEPTH:  lfo_fast_depth  <= cfg_data[DEPTH_W-1:0];
        REG_LFO_SLOW_DEPTH:  lfo_slow_depth  <= cfg_data[DEPTH_W-1:0];
        REG_FREQ_SCALE:      freq_scale      <= cfg_data[SCALE_W-1:0];
        REG_DRIVE_GAIN:      drive_gain      <= cfg_data[GAIN_W-1:0];
        REG_OUTPUT_SWING:    output_swing    <= cfg_data[LEVEL_W-1:0];
        REG_OUTPUT_MIDPOINT: output_midpoint <= cfg_data[LEVEL_W-1:0];
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, input ready and output load.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_RD_FAST;
        end
      end
      ST_RD_FAST: state_next = ST_RD_SLOW;
      ST_RD_SLOW: state_next = ST_VIB;
      ST_VIB:     state_next = ST_BASE;
      ST_BASE:    state_next = ST_PHI;
      ST_PHI:     state_next = ST_PLO;
      ST_PLO:     state_next = ST_LOW;
      ST_LOW:     state_next = ST_STEP;
      ST_STEP:    state_next = ST_ADV;
      ST_ADV:     state_next = ST_RD_TONE;
      ST_RD_TONE: state_next = ST_MAG;
      ST_MAG:     state_next = ST_DRV;
      ST_DRV:     state_next = ST_TADDR;
      ST_TADDR:   state_next = ST_SWING;
      ST_SWING:   state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  assign sine_abs    = sine_q[TABLE_W-1] ? TABLE_W'(-sine_q) : TABLE_W'(sine_q);
  assign tanh_signed = sine_neg ? -$signed({1'b0, tanh_q}) : $signed({1'b0, tanh_q});

  always_comb begin
    unique case (state)
      ST_RD_SLOW: begin
        mul_a = MUL_A_W'(sine_q);
        mul_b = $signed({3'b0, lfo_fast_depth});
      end
      ST_VIB: begin
        mul_a = MUL_A_W'(sine_q);
        mul_b = $signed({3'b0, lfo_slow_depth});
      end
      ST_BASE: begin
        mul_a = $signed({10'b0, freq_scale});
        mul_b = $signed({3'b0, tone_freq});
      end
      ST_PHI: begin
        mul_a = $signed({2'b0, base});
        mul_b = $signed({2'b0, mag[32:16]});
      end
      ST_PLO: begin
        mul_a = $signed({2'b0, base});
        mul_b = $signed({3'b0, mag[15:0]});
      end
      ST_MAG: begin
        mul_a = $signed({18'b0, sine_abs});
        mul_b = $signed({10'b0, volume});
      end
      ST_DRV: begin
        mul_a = $signed({10'b0, acc[23:0]});
        mul_b = $signed({3'b0, drive_gain});
      end
      ST_SWING: begin
        mul_a = MUL_A_W'(tanh_signed);
        mul_b = $signed({11'b0, output_swing});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Table addresses: the sine port follows the step, the tanh address clamps.
  always_comb begin
    unique case (state)
      ST_RD_FAST: sine_addr = fast_lfo_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      ST_RD_SLOW: sine_addr = slow_lfo_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      default:    sine_addr = tone_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    endcase
  end

  assign x_sh      = acc[39:TSHIFT];
  assign tanh_addr = (|x_sh[XSH_W-1:TANH_ADDR_BITS]) ? '1 : x_sh[TANH_ADDR_BITS-1:0];

  vts_tables #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .TANH_ADDR_BITS (TANH_ADDR_BITS)
  ) u_tables (
    .clk       (clk),
    .sine_addr (sine_addr),
    .tanh_addr (tanh_addr),
    .sine_q    (sine_q),
    .tanh_q    (tanh_q)
  );

  // Helpers for the vibrato magnitude, the tone step and the output level.
  assign acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
  assign step_sum = 35'(p_hi[49:15]) + 35'(acc[49:31]);
  assign total    = $signed({3'b0, output_midpoint, 15'b0}) + $signed(acc[25:0]);

  always_comb begin
    if (total[25]) begin
      sample_next = '0;
    end else if (|total[24:23]) begin
      sample_next = '1;
    end else begin
      sample_next = total[22:15];
    end
  end

  // Phase accumulators advance in their own steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_phase     <= '0;
      fast_lfo_phase <= '0;
      slow_lfo_phase <= '0;
    end else begin
      if (state == ST_VIB) begin
        fast_lfo_phase <= fast_lfo_phase + lfo_fast_step[STEP_W-1 -: PHASE_BITS];
        slow_lfo_phase <= slow_lfo_phase + lfo_slow_step[STEP_W-1 -: PHASE_BITS];
      end
      if (state == ST_ADV) begin
        tone_phase <= vib_neg ? (tone_phase - step) : (tone_phase + step);
      end
    end
  end

  // Datapath registers, loaded by sequencer step.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          tone_freq <= s_tdata[FREQ_W-1:0];
          volume    <= s_tdata[FREQ_W +: VOL_W];
        end
      end
      ST_RD_SLOW: acc <= prod[ACC_W-1:0] + (ACC_W'(1) << 31);
      ST_VIB:     acc <= acc + prod[ACC_W-1:0];
      ST_BASE: begin
        base    <= prod[39:8];
        vib_neg <= acc[ACC_W-1];
        mag     <= acc_abs[32:0];
      end
      ST_PHI:   p_hi <= prod[49:0];
      ST_PLO:   acc  <= prod[ACC_W-1:0];
      ST_LOW:   acc  <= acc + ACC_W'({p_hi[14:0], 16'b0});
      ST_STEP:  step <= step_sum[31 -: PHASE_BITS];
      ST_MAG: begin
        sine_neg <= sine_q[TABLE_W-1];
        acc      <= prod[ACC_W-1:0];
      end
      ST_DRV:   acc <= prod[ACC_W-1:0];
      ST_SWING: acc <= prod[ACC_W-1:0];
      default: begin
      end
    endcase
  end

  // Output register: holds the word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= sample_next;
    end
  end

endmodule

/* hw/rtl/vts_checker.sv */
// ----------------------------------------------------------------------------
// vts_checker
// Port-level checks for the vibrato tone synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "vibrato_tone_synth_assert.svh"

module vts_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // A stalled output word stays put.
  `VTS_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

  // Reset leaves no word pending and the input open.
  `VTS_ASSERT_ALWAYS_NXT(a_rst_state, clk, rst, !m_tvalid && s_tready, "bad state after reset")

  // One word is computed at a time.
  `VTS_ASSERT_NXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while busy")

  // A new sample cannot show up in the cycle after a word is taken.
  `VTS_ASSERT_NXT(a_no_early, clk, rst, s_tvalid && s_tready, !$rose(m_tvalid), "sample appeared too early")

endmodule

bind vibrato_tone_synth vts_checker u_vts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
